// File: hdl/gld_pkg.sv
// Shared types and constants of the GIF LZW decoder.
package gld_pkg;

	localparam int BufBits  = 24;
	localparam int FillBits = 5;
	localparam int CntBits  = 24;

	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_PULL    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	localparam logic [2:0] ST_PIXEL   = 3'd0;
	localparam logic [2:0] ST_TAKEN   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NEED    = 3'd3;
	localparam logic [2:0] ST_END     = 3'd4;
	localparam logic [2:0] ST_FRAME   = 3'd5;
	localparam logic [2:0] ST_RESTART = 3'd6;

	localparam logic [0:0] REG_MIN_CODE = 1'd0;
	localparam logic [0:0] REG_PIX_CNT  = 1'd1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} gld_in_t;

	typedef struct packed {
		logic [7:0] pixel_index;
		logic [2:0] status;
		logic       error_flag;
		logic       last_pixel;
	} gld_out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_CODE,
		S_WALK_RD,
		S_WALK,
		S_ADD,
		S_POP_RD,
		S_POP,
		S_DONE
	} gld_state_t;

endpackage

// File: hdl/gld_regs.sv
// Configuration register file with APB-style access.
module gld_regs import gld_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:2]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  min_bits,
	output logic [CntBits-1:0] pixel_count
);

	logic [3:0]         min_q;
	logic [CntBits-1:0] cnt_q;

	assign pready = 1'b1;
	assign min_bits = min_q;
	assign pixel_count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= 4'd8;
			cnt_q <= 24'd65536;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MIN_CODE: min_q <= pwdata[3:0];
				REG_PIX_CNT:  cnt_q <= pwdata[CntBits-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MIN_CODE: prdata = {28'd0, min_q};
			REG_PIX_CNT:  prdata = {8'd0, cnt_q};
			default:      prdata = '0;
		endcase
	end

endmodule

// File: hdl/gif_lzw_decoder_top.sv
// Top level of the GIF LZW decoder: handshake, sequencer, tables and stack.
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | gld_in_t (cmd, data_byte)
//  out     | output    | out_valid/out_stall| gld_out_t (pixel, status, flags)
//  apb     | input     | psel/penable       | min_code_size, pixel_count
// Push, restart, repeated stop: DECIDE then DONE; pull short of bits or on a bad code: DECIDE, CODE, DONE.
// Pull from a filled stack: DECIDE, POP_RD, POP, DONE (registered stack read).
// Pull that decodes: DECIDE, CODE (again per clear code), WALK_RD/WALK per entry walked, ADD, POP_RD, POP, DONE.
// Reset clears control state; tables and stack are left unset.
// in_stall stays high from acceptance until the result is taken.
module gif_lzw_decoder_top import gld_pkg::*; #(
	parameter int MAX_CODE_BITS = 12,
	parameter int TABLE_DEPTH   = 4096,
	parameter int STACK_DEPTH   = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  gld_in_t     in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output gld_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:2]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TW = $clog2(TABLE_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(MAX_CODE_BITS + 1);
	localparam int NW = TW + 1;

	logic [3:0]         min_cs;
	logic [CntBits-1:0] pix_cnt;

	gld_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.min_bits(min_cs), .pixel_count(pix_cnt)
	);

	gld_state_t state_q, state_d;
	gld_state_t seq_next;
	logic       walk_go;
	logic       in_acc;

	logic [1:0]          cmd_q;
	logic [7:0]          byte_q;
	logic [SW:0]         sp_q;
	logic [BufBits-1:0]  buf_q;
	logic [FillBits-1:0] fill_q;
	logic [CW-1:0]       width_q;
	logic [NW-1:0]       nfc_q;
	logic [TW-1:0]       prev_q;
	logic                prev_v_q;
	logic [7:0]          first_q;
	logic [CntBits-1:0]  done_q;
	logic                fin_q;
	logic [2:0]          stop_st_q;
	logic                stop_err_q;
	logic [TW-1:0]       code_q;
	logic [TW:0]         cur_q;
	gld_out_t            res_q;
	logic                ovalid_q;

	logic [TW-1:0] prefix_mem [TABLE_DEPTH];
	logic [7:0]    suffix_mem [TABLE_DEPTH];
	logic [7:0]    stack_mem  [STACK_DEPTH];
	logic [TW-1:0] pre_rd_q;
	logic [7:0]    suf_rd_q;
	logic [7:0]    stk_rd_q;

	logic [3:0]  m_eff;
	logic [12:0] clear_c;
	logic [13:0] mask_full;
	logic [BufBits-1:0] code_raw;
	logic [12:0] code_v;

	always_comb begin
		if (min_cs < 4'd2)      m_eff = 4'd2;
		else if (min_cs > 4'd8) m_eff = 4'd8;
		else                    m_eff = min_cs;
		clear_c  = 13'd1 << m_eff;
		mask_full = (14'd1 << width_q) - 14'd1;
		code_raw = buf_q & {10'd0, mask_full};
		code_v   = code_raw[12:0];
	end

	assign in_stall  = (state_q != S_IDLE) || ovalid_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = ovalid_q;
	assign out_data  = res_q;

	always_comb begin
		walk_go = (cur_q >= {1'b0, clear_c[TW-1:0]} + (TW+1)'(2)) && (cur_q < (TW+1)'(TABLE_DEPTH))
			&& (sp_q < (SW+1)'(STACK_DEPTH));
		seq_next = state_q;
		if (state_q == S_CODE) begin
			if (fill_q < FillBits'(width_q)) seq_next = S_DONE;
			else if (code_v == clear_c) seq_next = S_CODE;
			else if (code_v == clear_c + 13'd1) seq_next = S_DONE;
			else if ({1'b0, code_v} > {1'b0, nfc_q} || code_v >= 13'(TABLE_DEPTH)
				|| ({1'b0, code_v} >= {1'b0, nfc_q} && !prev_v_q)) seq_next = S_DONE;
			else seq_next = S_WALK_RD;
		end else if (state_q == S_WALK) begin
			seq_next = walk_go ? S_WALK_RD : S_ADD;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (in_acc) state_d = S_DECIDE;
			S_DECIDE: begin
				if (cmd_q != CMD_PULL || fin_q || done_q >= pix_cnt) state_d = S_DONE;
				else if (sp_q != '0) state_d = S_POP_RD;
				else state_d = S_CODE;
			end
			S_CODE:    state_d = S_CODE;
			S_WALK_RD: state_d = S_WALK;
			S_WALK:    state_d = S_WALK;
			S_ADD:     state_d = S_POP_RD;
			S_POP_RD:  state_d = S_POP;
			S_POP:     state_d = S_DONE;
			S_DONE:    if (!ovalid_q) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
		// data-dependent exits resolved in the sequencer block above
		if (state_q == S_CODE || state_q == S_WALK) state_d = seq_next;
	end

	always_ff @(posedge clk) begin
		pre_rd_q <= prefix_mem[cur_q[TW-1:0]];
		suf_rd_q <= suffix_mem[cur_q[TW-1:0]];
		stk_rd_q <= stack_mem[SW'(sp_q - (SW+1)'(1))];
		if (state_q == S_CODE && seq_next == S_WALK_RD && {1'b0, code_v} == {1'b0, nfc_q})
			stack_mem[0] <= first_q;
		if (state_q == S_WALK) begin
			if (walk_go) stack_mem[sp_q[SW-1:0]] <= suf_rd_q;
			else if (sp_q < (SW+1)'(STACK_DEPTH)) stack_mem[sp_q[SW-1:0]] <= cur_q[7:0];
		end
		if (state_q == S_ADD && prev_v_q && nfc_q < NW'(TABLE_DEPTH)) begin
			prefix_mem[nfc_q[TW-1:0]] <= prev_q;
			suffix_mem[nfc_q[TW-1:0]] <= first_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ovalid_q <= 1'b0; cmd_q <= '0; byte_q <= '0;
			sp_q <= '0; buf_q <= '0; fill_q <= '0; width_q <= CW'(9);
			nfc_q <= NW'(258); prev_q <= '0; prev_v_q <= 1'b0; first_q <= '0;
			done_q <= '0; fin_q <= 1'b0; stop_st_q <= '0; stop_err_q <= 1'b0;
			code_q <= '0; cur_q <= '0; res_q <= '0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					cmd_q <= in_data.cmd; byte_q <= in_data.data_byte;
				end
				S_DECIDE: begin
					res_q <= '0;
					priority if (cmd_q == CMD_PUSH) begin
						if (fill_q <= 5'd16) begin
							buf_q <= buf_q | (BufBits'(byte_q) << fill_q);
							fill_q <= fill_q + 5'd8;
							res_q.status <= ST_TAKEN;
						end else res_q.status <= ST_FULL;
					end else if (cmd_q == CMD_RESTART) begin
						sp_q <= '0; buf_q <= '0; fill_q <= '0;
						width_q <= CW'(m_eff + 4'd1);
						nfc_q <= NW'(clear_c + 13'd2);
						prev_q <= '0; prev_v_q <= 1'b0; first_q <= '0; done_q <= '0;
						fin_q <= 1'b0; stop_st_q <= '0; stop_err_q <= 1'b0;
						res_q.status <= ST_RESTART;
					end else if (cmd_q != CMD_PULL) begin
						res_q.status <= ST_FULL;
					end else if (fin_q) begin
						res_q.status <= stop_st_q; res_q.error_flag <= stop_err_q;
					end else if (done_q >= pix_cnt) begin
						fin_q <= 1'b1; stop_st_q <= ST_FRAME; stop_err_q <= 1'b0;
						res_q.status <= ST_FRAME;
					end else if (width_q > CW'(MAX_CODE_BITS)) width_q <= CW'(MAX_CODE_BITS);
				end
				S_CODE: begin
					if (seq_next == S_DONE && fill_q < 5'(width_q)) begin
						res_q.status <= ST_NEED;
					end else begin
						buf_q <= buf_q >> width_q;
						fill_q <= fill_q - 5'(width_q);
						if (seq_next == S_CODE) begin
							width_q <= CW'(m_eff + 4'd1);
							nfc_q <= NW'(clear_c + 13'd2);
							prev_v_q <= 1'b0;
						end else if (seq_next == S_DONE) begin
							fin_q <= 1'b1; stop_st_q <= ST_END;
							stop_err_q <= (code_v != clear_c + 13'd1);
							res_q.status <= ST_END;
							res_q.error_flag <= (code_v != clear_c + 13'd1);
						end else begin
							code_q <= code_v[TW-1:0];
							if ({1'b0, code_v} == {1'b0, nfc_q}) begin
								sp_q <= (SW+1)'(1);
								cur_q <= {1'b0, prev_q};
							end else begin
								sp_q <= '0;
								cur_q <= code_v[TW:0];
							end
						end
					end
				end
				S_WALK: begin
					if (walk_go) begin
						sp_q <= sp_q + (SW+1)'(1);
						cur_q <= {1'b0, pre_rd_q};
					end else begin
						if (sp_q < (SW+1)'(STACK_DEPTH)) begin
							sp_q <= sp_q + (SW+1)'(1);
							first_q <= cur_q[7:0];
						end
					end
				end
				S_ADD: begin
					if (prev_v_q && nfc_q < NW'(TABLE_DEPTH)) begin
						nfc_q <= nfc_q + NW'(1);
						if ((nfc_q + NW'(1)) >= (NW'(1) << width_q)
							&& width_q < CW'(MAX_CODE_BITS)) width_q <= width_q + CW'(1);
					end
					prev_q <= code_q; prev_v_q <= 1'b1;
				end
				S_POP: begin
					sp_q <= sp_q - (SW+1)'(1);
					res_q.pixel_index <= stk_rd_q;
					res_q.status <= ST_PIXEL;
					done_q <= done_q + CntBits'(1);
					if (done_q + CntBits'(1) >= pix_cnt) begin
						res_q.last_pixel <= 1'b1;
						fin_q <= 1'b1; stop_st_q <= ST_FRAME; stop_err_q <= 1'b0;
					end
				end
				S_DONE: if (!ovalid_q) ovalid_q <= 1'b1;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && out_stall |=> ovalid_q) else $error("result dropped");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= (SW+1)'(STACK_DEPTH)) else $error("stack overflow");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 5'd24) else $error("bit buffer overfilled");
`endif

endmodule
